@@ rtl/ffha_pkg.sv @@
`default_nettype none
package ffha_pkg;
  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned HW = $clog2(MAX_BLOCKS);
  localparam int unsigned LW = HW + 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);
  localparam int unsigned ADDR_BITS = 32;
  localparam logic [31:0] CAP_RESET = 32'd52428800;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_HANDLE = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;
endpackage
`default_nettype wire

@@ rtl/first_fit_heap_allocator_unit.sv @@
`default_nettype none
// channel  handshake             payload
// in       start & !busy         in_mode, in_req_size, in_free_offset, in_free_handle
// out      out_valid (1 cycle)   out_grant_offset, out_grant_size, out_grant_handle, out_status
// cfg      cfg_valid & cfg_ready cfg_data (heap capacity)
//
// The free-list walk visits one entry per cycle through the link RAM read port.
// Free: a handle check (S_FCHK), a walk over the entries, then S_WDONE, S_INSA and
// S_INSB. Allocate: a fit walk and S_WDONE, plus S_RESTART, a second walk, S_INSA and
// S_INSB when a remainder is reinserted. A capacity refusal answers in the
// cycle after the transfer without raising busy; otherwise busy covers the item.
// Synchronous active-low reset; no RAM clearing pass is needed.
// The result strobe cannot be stalled.
module first_fit_heap_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_req_size,
  input  wire logic [31:0] in_free_offset,
  input  wire logic [ffha_pkg::HW-1:0] in_free_handle,
  output logic             out_valid,
  output logic [31:0]      out_grant_offset,
  output logic [31:0]      out_grant_size,
  output logic [ffha_pkg::HW-1:0] out_grant_handle,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  localparam int unsigned HW = ffha_pkg::HW;
  localparam int unsigned LW = ffha_pkg::LW;

  typedef enum logic [2:0] {
    S_IDLE, S_FCHK, S_WALK, S_WDONE, S_RESTART, S_INSA, S_INSB
  } state_t;
  typedef enum logic [1:0] {PH_FREE, PH_ALLOC, PH_REINS} phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic          walk_fit_r, walk_fit_nxt;
  logic [31:0]   sz_r, sz_nxt, key_r, key_nxt, ins_len_r, ins_len_nxt;
  logic [HW-1:0] ins_h_r, ins_h_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, pos_r, pos_nxt;
  logic [31:0]   hit_off_r, hit_off_nxt, hit_len_r, hit_len_nxt;
  logic [LW-1:0] hit_next_r, hit_next_nxt, head_r, head_nxt, nnh_r, nnh_nxt;
  logic [31:0]   bump_r, bump_nxt, cap_r, cap_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_off_r, out_off_nxt, out_size_r, out_size_nxt;
  logic [HW-1:0] out_h_r, out_h_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  logic          ol_we, fl_we, il_we, il_wdata;
  logic [HW-1:0] ol_waddr, fl_waddr, il_waddr, rd_addr;
  logic [63:0]   ol_wdata, ol_rdata;
  logic [LW-1:0] fl_wdata, fl_rdata;
  logic          il_rdata;

  ffha_ram #(.WIDTH(64), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_ol (
    .clk(clk), .we(ol_we), .waddr(ol_waddr), .wdata(ol_wdata),
    .raddr(rd_addr), .rdata(ol_rdata));
  ffha_ram #(.WIDTH(LW), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_fl (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(rd_addr), .rdata(fl_rdata));
  ffha_ram #(.WIDTH(1), .DEPTH(ffha_pkg::MAX_BLOCKS)) u_il (
    .clk(clk), .we(il_we), .waddr(il_waddr), .wdata(il_wdata),
    .raddr(in_free_handle), .rdata(il_rdata));

  // shared compare: fit walk tests size <= length, position walk key <= offset
  logic [31:0] cmp_a, cmp_b;
  logic        walk_hit;
  assign cmp_a    = walk_fit_r ? sz_r : key_r;
  assign cmp_b    = walk_fit_r ? ol_rdata[31:0] : ol_rdata[63:32];
  assign walk_hit = !(cmp_a > cmp_b);
  assign rd_addr  = (state_r == S_WALK) ? fl_rdata[HW-1:0] : head_r[HW-1:0];

  logic [32:0] cap_sum;
  logic [31:0] rem;
  assign cap_sum = {1'b0, bump_r} + {1'b0, in_req_size};
  assign rem     = hit_len_r - sz_r;

  assign busy             = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_grant_offset = out_off_r;
  assign out_grant_size   = out_size_r;
  assign out_grant_handle = out_h_r;
  assign out_status       = out_st_r;

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; walk_fit_nxt = walk_fit_r;
    sz_nxt = sz_r; key_nxt = key_r; ins_len_nxt = ins_len_r; ins_h_nxt = ins_h_r;
    cur_nxt = cur_r; prev_nxt = prev_r; pos_nxt = pos_r;
    hit_off_nxt = hit_off_r; hit_len_nxt = hit_len_r; hit_next_nxt = hit_next_r;
    head_nxt = head_r; nnh_nxt = nnh_r; bump_nxt = bump_r; cap_nxt = cap_r;
    out_valid_nxt = 1'b0; out_off_nxt = out_off_r; out_size_nxt = out_size_r;
    out_h_nxt = out_h_r; out_st_nxt = out_st_r;
    ol_we = 1'b0; ol_waddr = ins_h_r; ol_wdata = {key_r, ins_len_r};
    fl_we = 1'b0; fl_waddr = ins_h_r; fl_wdata = pos_r;
    il_we = 1'b0; il_waddr = ins_h_r; il_wdata = 1'b1;
    if (cfg_valid) begin
      cap_nxt = cfg_data;
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          sz_nxt = in_req_size; key_nxt = in_free_offset;
          ins_h_nxt = in_free_handle; ins_len_nxt = in_req_size;
          out_off_nxt = '0; out_size_nxt = '0; out_h_nxt = '0;
          out_st_nxt = ffha_pkg::ST_OK;
          if (in_mode) begin
            phase_nxt = PH_FREE;
            state_nxt = S_FCHK;
          end else if (cap_sum > {1'b0, cap_r}) begin
            out_st_nxt = ffha_pkg::ST_NO_SPACE;
            out_valid_nxt = 1'b1;
          end else begin
            phase_nxt = PH_ALLOC;
            walk_fit_nxt = 1'b1;
            prev_nxt = ffha_pkg::NIL; pos_nxt = ffha_pkg::NIL; cur_nxt = head_r;
            state_nxt = (head_r == ffha_pkg::NIL) ? S_WDONE : S_WALK;
          end
        end
      end
      S_FCHK: begin
        if ({1'b0, ins_h_r} >= nnh_r || il_rdata) begin
          out_st_nxt = ffha_pkg::ST_BAD_HANDLE;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          walk_fit_nxt = 1'b0;
          prev_nxt = ffha_pkg::NIL; pos_nxt = ffha_pkg::NIL; cur_nxt = head_r;
          state_nxt = (head_r == ffha_pkg::NIL) ? S_WDONE : S_WALK;
        end
      end
      S_RESTART: begin
        walk_fit_nxt = 1'b0;
        prev_nxt = ffha_pkg::NIL; pos_nxt = ffha_pkg::NIL; cur_nxt = head_r;
        state_nxt = (head_r == ffha_pkg::NIL) ? S_WDONE : S_WALK;
      end
      S_WALK: begin
        if (walk_hit) begin
          pos_nxt = cur_r;
          hit_off_nxt = ol_rdata[63:32];
          hit_len_nxt = ol_rdata[31:0];
          hit_next_nxt = fl_rdata;
          state_nxt = S_WDONE;
        end else begin
          prev_nxt = cur_r;
          cur_nxt = fl_rdata;
          if (fl_rdata == ffha_pkg::NIL) begin
            state_nxt = S_WDONE;
          end
        end
      end
      S_WDONE: begin
        unique case (phase_r)
          PH_FREE: begin
            if (pos_r != ffha_pkg::NIL && hit_off_r == key_r) begin
              out_st_nxt = ffha_pkg::ST_BAD_HANDLE;
              out_valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_INSA;
            end
          end
          PH_ALLOC: begin
            if (pos_r != ffha_pkg::NIL) begin
              if (rem != '0 && nnh_r == ffha_pkg::NIL) begin
                out_st_nxt = ffha_pkg::ST_NO_HANDLE;
                out_valid_nxt = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                // unlink the hit entry
                if (prev_r != ffha_pkg::NIL) begin
                  fl_we = 1'b1; fl_waddr = prev_r[HW-1:0]; fl_wdata = hit_next_r;
                end else begin
                  head_nxt = hit_next_r;
                end
                il_we = 1'b1; il_waddr = pos_r[HW-1:0]; il_wdata = 1'b0;
                out_off_nxt = hit_off_r; out_size_nxt = sz_r; out_h_nxt = pos_r[HW-1:0];
                if (rem != '0) begin
                  ins_h_nxt = nnh_r[HW-1:0];
                  nnh_nxt = nnh_r + LW'(1);
                  key_nxt = hit_off_r + sz_r;
                  ins_len_nxt = rem;
                  phase_nxt = PH_REINS;
                  state_nxt = S_RESTART;
                end else begin
                  out_valid_nxt = 1'b1;
                  state_nxt = S_IDLE;
                end
              end
            end else if (nnh_r == ffha_pkg::NIL) begin
              out_st_nxt = ffha_pkg::ST_NO_HANDLE;
              out_valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              il_we = 1'b1; il_waddr = nnh_r[HW-1:0]; il_wdata = 1'b0;
              out_off_nxt = bump_r; out_size_nxt = sz_r; out_h_nxt = nnh_r[HW-1:0];
              nnh_nxt = nnh_r + LW'(1);
              bump_nxt = bump_r + sz_r;
              out_valid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_INSA;
          end
        endcase
      end
      S_INSA: begin
        ol_we = 1'b1;
        fl_we = 1'b1;
        il_we = 1'b1;
        if (prev_r == ffha_pkg::NIL) begin
          head_nxt = {1'b0, ins_h_r};
        end
        state_nxt = S_INSB;
      end
      S_INSB: begin
        if (prev_r != ffha_pkg::NIL) begin
          fl_we = 1'b1; fl_waddr = prev_r[HW-1:0]; fl_wdata = {1'b0, ins_h_r};
        end
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_FREE;
      head_r <= ffha_pkg::NIL;
      nnh_r <= '0;
      bump_r <= '0;
      cap_r <= ffha_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      head_r <= head_nxt;
      nnh_r <= nnh_nxt;
      bump_r <= bump_nxt;
      cap_r <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
    walk_fit_r <= walk_fit_nxt;
    sz_r <= sz_nxt; key_r <= key_nxt; ins_len_r <= ins_len_nxt; ins_h_r <= ins_h_nxt;
    cur_r <= cur_nxt; prev_r <= prev_nxt; pos_r <= pos_nxt;
    hit_off_r <= hit_off_nxt; hit_len_r <= hit_len_nxt; hit_next_r <= hit_next_nxt;
    out_off_r <= out_off_nxt; out_size_r <= out_size_nxt;
    out_h_r <= out_h_nxt; out_st_r <= out_st_nxt;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE) else $error("result while busy");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ffha_pkg::ST_OK) |->
      (out_off_r == '0 && out_size_r == '0 && out_h_r == '0))
    else $error("nonzero grant on error");
  a_nnh_max: assert property (@(posedge clk) disable iff (!rst_n)
    nnh_r <= ffha_pkg::NIL) else $error("handle counter overrun");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid_r)) else $error("request dropped");
endmodule
`default_nettype wire

@@ rtl/ffha_ram.sv @@
`default_nettype none
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
module tb_top;
  localparam int unsigned HW = ffha_pkg::HW;
  localparam int unsigned LW = ffha_pkg::LW;

  typedef struct packed {
    logic [31:0]   offset;
    logic [31:0]   size;
    logic [HW-1:0] handle;
    logic [1:0]    status;
  } grant_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          in_mode;
  logic [31:0]   in_req_size;
  logic [31:0]   in_free_offset;
  logic [HW-1:0] in_free_handle;
  logic          out_valid;
  logic [31:0]   out_grant_offset;
  logic [31:0]   out_grant_size;
  logic [HW-1:0] out_grant_handle;
  logic [1:0]    out_status;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [31:0]   cfg_data;

  first_fit_heap_allocator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_req_size(in_req_size), .in_free_offset(in_free_offset),
    .in_free_handle(in_free_handle), .out_valid(out_valid),
    .out_grant_offset(out_grant_offset), .out_grant_size(out_grant_size),
    .out_grant_handle(out_grant_handle), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // heap shadow state
  logic [31:0]   cap_q;
  logic [32:0]   top_q;
  logic [LW-1:0] next_h;
  logic [LW-1:0] head_q, tail_q;
  logic [31:0]   ent_off [ffha_pkg::MAX_BLOCKS];
  logic [31:0]   ent_len [ffha_pkg::MAX_BLOCKS];
  logic [LW-1:0] fwd [ffha_pkg::MAX_BLOCKS];
  logic [LW-1:0] bwd [ffha_pkg::MAX_BLOCKS];
  bit            listed [ffha_pkg::MAX_BLOCKS];

  grant_t grants_due[$];
  int     err_cnt;
  int     burst_left;
  // live (handle, offset, size) allocations, to free later
  logic [HW-1:0] live_h[$];
  logic [31:0]   live_off[$];
  logic [31:0]   live_sz[$];

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [LW-1:0] find_slot(logic [31:0] off);
    logic [LW-1:0] cur;
    cur = head_q;
    while (cur != ffha_pkg::NIL) begin
      if (off <= ent_off[cur]) return cur;
      cur = fwd[cur];
    end
    return ffha_pkg::NIL;
  endfunction

  function automatic void list_insert(logic [LW-1:0] h, logic [31:0] off, logic [31:0] len);
    logic [LW-1:0] cur, prv;
    cur = find_slot(off);
    prv = (cur != ffha_pkg::NIL) ? bwd[cur] : tail_q;
    ent_off[h] = off;
    ent_len[h] = len;
    fwd[h] = cur;
    bwd[h] = prv;
    if (prv != ffha_pkg::NIL) fwd[prv] = h; else head_q = h;
    if (cur != ffha_pkg::NIL) bwd[cur] = h; else tail_q = h;
    listed[h] = 1;
  endfunction

  function automatic void list_remove(logic [LW-1:0] h);
    logic [LW-1:0] p, n;
    p = bwd[h];
    n = fwd[h];
    if (p != ffha_pkg::NIL) fwd[p] = n; else head_q = n;
    if (n != ffha_pkg::NIL) bwd[n] = p; else tail_q = p;
    fwd[h] = ffha_pkg::NIL;
    bwd[h] = ffha_pkg::NIL;
    listed[h] = 0;
  endfunction

  function automatic void heap_reset();
    cap_q = ffha_pkg::CAP_RESET;
    top_q = 0;
    next_h = 0;
    head_q = ffha_pkg::NIL;
    tail_q = ffha_pkg::NIL;
    for (int i = 0; i < ffha_pkg::MAX_BLOCKS; i++) begin
      fwd[i] = ffha_pkg::NIL;
      bwd[i] = ffha_pkg::NIL;
      listed[i] = 0;
    end
  endfunction

  function automatic grant_t heap_predict(logic mode, logic [31:0] sz,
                                          logic [31:0] foff, logic [HW-1:0] fh);
    grant_t g;
    logic [LW-1:0] cur, hit, pos;
    logic [31:0] rem, base;
    g = '0;
    if (mode) begin
      if (LW'(fh) >= next_h || listed[fh]) begin
        g.status = ffha_pkg::ST_BAD_HANDLE;
      end else begin
        pos = find_slot(foff);
        if (pos != ffha_pkg::NIL && ent_off[pos] == foff) g.status = ffha_pkg::ST_BAD_HANDLE;
        else list_insert(LW'(fh), foff, sz);
      end
    end else if (top_q + 33'(sz) > 33'(cap_q)) begin
      g.status = ffha_pkg::ST_NO_SPACE;
    end else begin
      cur = head_q;
      hit = ffha_pkg::NIL;
      while (cur != ffha_pkg::NIL && hit == ffha_pkg::NIL) begin
        if (ent_len[cur] >= sz) hit = cur;
        else cur = fwd[cur];
      end
      if (hit != ffha_pkg::NIL) begin
        rem = ent_len[hit] - sz;
        if (rem != 0 && next_h >= ffha_pkg::NIL) begin
          g.status = ffha_pkg::ST_NO_HANDLE;
        end else begin
          base = ent_off[hit];
          list_remove(hit);
          if (rem != 0) begin
            list_insert(next_h, base + sz, rem);
            next_h++;
          end
          g.offset = base;
          g.size = sz;
          g.handle = hit[HW-1:0];
        end
      end else if (next_h >= ffha_pkg::NIL) begin
        g.status = ffha_pkg::ST_NO_HANDLE;
      end else begin
        g.offset = top_q[31:0];
        g.size = sz;
        g.handle = next_h[HW-1:0];
        next_h++;
        top_q = {1'b0, top_q[31:0] + sz};
      end
    end
    return g;
  endfunction

  // one transfer into the block; start stays high for a back-to-back transfer,
  // a gap or drain() drops it
  task automatic send_req(logic mode, logic [31:0] sz, logic [31:0] foff, logic [HW-1:0] fh);
    grant_t g;
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1;
    in_mode <= mode;
    in_req_size <= sz;
    in_free_offset <= foff;
    in_free_handle <= fh;
    do @(posedge clk); while (busy);
    g = heap_predict(mode, sz, foff, fh);
    grants_due.push_back(g);
    if (!mode && g.status == ffha_pkg::ST_OK) begin
      live_h.push_back(g.handle);
      live_off.push_back(g.offset);
      live_sz.push_back(g.size);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    cap_q = v;
  endtask

  task automatic free_live(int idx);
    logic [HW-1:0] h;
    logic [31:0] o, s;
    h = live_h[idx];
    o = live_off[idx];
    s = live_sz[idx];
    live_h.delete(idx);
    live_off.delete(idx);
    live_sz.delete(idx);
    send_req(1, s, o, h);
  endtask

  always @(posedge clk) begin
    grant_t e;
    if (rst_n && out_valid) begin
      if (grants_due.size() == 0) begin
        $error("result with nothing expected");
        err_cnt++;
      end else begin
        e = grants_due.pop_front();
        if (out_grant_offset !== e.offset) begin
          $error("grant_offset exp %h got %h", e.offset, out_grant_offset); err_cnt++;
        end
        if (out_grant_size !== e.size) begin
          $error("grant_size exp %h got %h", e.size, out_grant_size); err_cnt++;
        end
        if (out_grant_handle !== e.handle) begin
          $error("grant_handle exp %0d got %0d", e.handle, out_grant_handle); err_cnt++;
        end
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(0, 32'd100, 0, 0);
    send_req(0, 32'd0, 0, 0);
    send_req(0, 32'd200, 0, 0);
    send_req(0, 32'hFFFF_FFFF, 0, 0);          // capacity refusal
    send_req(1, 32'd100, 32'd0, 10'd0);         // free handle 0
    send_req(1, 32'd100, 32'd0, 10'd0);         // already listed
    send_req(1, 32'd5, 32'd0, 10'd2);           // duplicate offset
    send_req(1, 32'd5, 32'd7, 10'd1023);        // never issued
    send_req(0, 32'd0, 0, 0);                   // zero size takes whole entry as remainder
    send_req(0, 32'd40, 0, 0);
    send_req(1, 32'd200, 32'd100, 10'd2);
    send_req(0, 32'd200, 0, 0);                 // exact fit
    free_live(0);
    send_req(0, 32'd60, 0, 0);
  endtask

  task automatic test_capacity_extremes();
    write_capacity(32'd1);
    send_req(0, 32'd1, 0, 0);
    send_req(0, 32'd1, 0, 0);
    write_capacity(32'hFFFF_FFFF);
    send_req(0, 32'hFFFF_0000, 0, 0);
    send_req(0, 32'hFFFF_FFFF, 0, 0);
    write_capacity(32'd5000);
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        send_req(0, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64), 0, 0);
      end else if (k < 85 && live_h.size() != 0) begin
        free_live($urandom_range(0, live_h.size() - 1));
      end else begin
        send_req(1, $urandom, $urandom, HW'($urandom));
      end
      if (i == n / 2) drain();                  // full pause until quiet
    end
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_mode = 0;
    in_req_size = 0;
    in_free_offset = 0;
    in_free_handle = 0;
    cfg_valid = 0;
    cfg_data = 0;
    err_cnt = 0;
    burst_left = 0;
    heap_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(290);
    write_capacity(32'd300000);
    test_random(270);
    // pushes the bump top near the end of the address space, so it runs last
    test_capacity_extremes();
    drain();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ first_fit_heap_allocator_unit.f @@
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_unit.sv
verif/tb_top.sv
